// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent holds, consequent holds in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// antecedent holds, consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/pdc_pkg.sv =====
`timescale 1ns / 1ps
package pdc_pkg;
	localparam int NBANDS = 32;
	localparam int NTAPS = 8;
	localparam int HLEN = NBANDS * NTAPS;
	localparam int BAND_W = $clog2(NBANDS);
	localparam int TAP_W = $clog2(NTAPS);
	localparam int ADDR_W = $clog2(HLEN);
	localparam int SAMPLE_W = 16;
	localparam int COEF_W = 18;
	localparam int POUT_W = SAMPLE_W + COEF_W + TAP_W;
	localparam int PHASE_W = 6;
	localparam int DECIM_W = 3;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF = 1'b1;

	typedef logic signed [POUT_W-1:0] pout_t;

	// one polyphase sum on its way into the transform scratch store
	typedef struct packed {
		logic valid;
		logic [BAND_W-1:0] m;
		pout_t data;
	} pout_wr_t;

	typedef struct packed {
		logic clearing;
		logic busy;
		logic done;
	} pp_status_t;
endpackage

// ===== rtl/core/pdc_polyphase.sv =====
`timescale 1ns / 1ps
module pdc_polyphase import pdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic smp_we,
	input logic signed [SAMPLE_W-1:0] smp_data,
	input logic frame_start,
	input logic coef_we,
	input logic [ADDR_W-1:0] coef_addr,
	input logic signed [COEF_W-1:0] coef_data,
	output pout_wr_t pout_wr,
	output pp_status_t status
);
	logic signed [SAMPLE_W-1:0] hist_mem [HLEN];
	logic signed [COEF_W-1:0] coef_mem [HLEN];

	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic clr_q;
	logic run_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [BAND_W-1:0] cur_m;
	logic [TAP_W-1:0] cur_k;
	logic [ADDR_W-1:0] coef_ra;
	logic [ADDR_W-1:0] hist_ra;
	logic hist_we;
	logic [ADDR_W-1:0] hist_wa;
	logic signed [SAMPLE_W-1:0] hist_wd;

	logic v_s1, first_s1, last_s1;
	logic [BAND_W-1:0] m_s1;
	logic signed [SAMPLE_W-1:0] hist_rd_s1;
	logic signed [COEF_W-1:0] coef_rd_s1;
	logic v_s2, first_s2, last_s2;
	logic [BAND_W-1:0] m_s2;
	logic signed [SAMPLE_W+COEF_W-1:0] prod_s2;
	pout_t acc_q;
	pout_t acc_sum;
	logic wr_v_s3;
	logic [BAND_W-1:0] wr_m_s3;
	pout_t wr_data_s3;

	// counter holds {m, k}; tap address is k*NBANDS + m
	assign cur_m = cnt_q[ADDR_W-1:TAP_W];
	assign cur_k = cnt_q[TAP_W-1:0];
	assign coef_ra = {cur_k, cur_m};
	assign hist_ra = ptr_q - ADDR_W'(1) - {cur_k, cur_m};

	// history write: clearing pass after reset, else new samples
	always_comb begin
		if (clr_q) begin
			hist_we = 1'b1;
			hist_wa = clr_cnt_q;
			hist_wd = '0;
		end else begin
			hist_we = smp_we;
			hist_wa = ptr_q;
			hist_wd = smp_data;
		end
	end

	// memories with registered read
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
		if (coef_we) begin
			coef_mem[coef_addr] <= coef_data;
		end
		hist_rd_s1 <= hist_mem[hist_ra];
		coef_rd_s1 <= coef_mem[coef_ra];
	end

	// sequencer and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			ptr_q <= '0;
			run_q <= 1'b0;
			cnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			wr_v_s3 <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
				if (clr_cnt_q == ADDR_W'(HLEN - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (smp_we) begin
				ptr_q <= ptr_q + ADDR_W'(1);
			end
			if (frame_start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + ADDR_W'(1);
				if (cnt_q == ADDR_W'(HLEN - 1)) begin
					run_q <= 1'b0;
				end
			end
			v_s1 <= run_q;
			v_s2 <= v_s1;
			wr_v_s3 <= v_s2 & last_s2;
		end
	end

	assign acc_sum = (first_s2 ? '0 : acc_q) + POUT_W'(prod_s2);

	// multiply and accumulate over the taps of one phase
	always_ff @(posedge clk) begin
		first_s1 <= (cur_k == '0);
		last_s1 <= (cur_k == TAP_W'(NTAPS - 1));
		m_s1 <= cur_m;
		prod_s2 <= hist_rd_s1 * coef_rd_s1;
		first_s2 <= first_s1;
		last_s2 <= last_s1;
		m_s2 <= m_s1;
		if (v_s2) begin
			acc_q <= acc_sum;
			wr_data_s3 <= acc_sum;
			wr_m_s3 <= m_s2;
		end
	end

	assign pout_wr.valid = wr_v_s3;
	assign pout_wr.m = wr_m_s3;
	assign pout_wr.data = wr_data_s3;
	assign status.clearing = clr_q;
	assign status.busy = run_q | v_s1 | v_s2 | wr_v_s3;
	assign status.done = wr_v_s3 && (wr_m_s3 == BAND_W'(NBANDS - 1));
endmodule

// ===== rtl/core/pdc_dft.sv =====
`timescale 1ns / 1ps
module pdc_dft import pdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input pout_wr_t pout_wr,
	input logic start,
	input logic res_take,
	output logic res_valid,
	output logic [BAND_W-1:0] res_band,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic res_last,
	output logic busy
);
	localparam int TWF = 29;
	localparam int TW_W = TWF + 2;
	localparam int LO_W = 19;
	localparam int HI_W = POUT_W - LO_W;
	localparam int LP_W = LO_W + 1 + TW_W;
	localparam int HP_W = HI_W + TW_W;
	localparam int LACC_W = LP_W + BAND_W;
	localparam int HACC_W = HP_W + BAND_W;
	localparam int TOT_W = HACC_W + LO_W + 1;
	localparam int RSHIFT = SAMPLE_W + COEF_W - 2 + TWF - 15;
	localparam longint unsigned PI_HALF = 64'd843314857;
	localparam longint unsigned ONE = 64'd1 << TWF;

	typedef logic signed [TW_W-1:0] tw_tab_t [NBANDS];

	// one series step before the division, t * a * a in q29
	function automatic longint unsigned term(longint unsigned t, longint unsigned a);
		return (((t * a) >> TWF) * a) >> TWF;
	endfunction

	// taylor series of 8 terms, angle in q29
	function automatic longint series(longint unsigned a, bit is_sin);
		longint unsigned t;
		longint acc;
		if (is_sin) begin
			t = a;
			acc = longint'(t);
			t = term(t, a) / 64'd6;
			acc = acc - longint'(t);
			t = term(t, a) / 64'd20;
			acc = acc + longint'(t);
			t = term(t, a) / 64'd42;
			acc = acc - longint'(t);
			t = term(t, a) / 64'd72;
			acc = acc + longint'(t);
			t = term(t, a) / 64'd110;
			acc = acc - longint'(t);
			t = term(t, a) / 64'd156;
			acc = acc + longint'(t);
			t = term(t, a) / 64'd210;
			acc = acc - longint'(t);
		end else begin
			t = ONE;
			acc = longint'(t);
			t = term(t, a) / 64'd2;
			acc = acc - longint'(t);
			t = term(t, a) / 64'd12;
			acc = acc + longint'(t);
			t = term(t, a) / 64'd30;
			acc = acc - longint'(t);
			t = term(t, a) / 64'd56;
			acc = acc + longint'(t);
			t = term(t, a) / 64'd90;
			acc = acc - longint'(t);
			t = term(t, a) / 64'd132;
			acc = acc + longint'(t);
			t = term(t, a) / 64'd182;
			acc = acc - longint'(t);
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > longint'(ONE)) begin
			acc = longint'(ONE);
		end
		return acc;
	endfunction

	function automatic tw_tab_t build_tab(bit is_sin);
		tw_tab_t tab;
		int q;
		int rem;
		longint unsigned a;
		longint c, s, vc, vs;
		for (int r = 0; r < NBANDS; r++) begin
			q = (4 * r) / NBANDS;
			rem = 4 * r - q * NBANDS;
			a = (PI_HALF * longint'(rem) + NBANDS / 2) / NBANDS;
			c = series(a, 1'b0);
			s = series(a, 1'b1);
			unique case (q)
				0: begin vc = c; vs = s; end
				1: begin vc = -s; vs = c; end
				2: begin vc = -c; vs = -s; end
				default: begin vc = s; vs = -c; end
			endcase
			tab[r] = is_sin ? TW_W'(vs) : TW_W'(vc);
		end
		return tab;
	endfunction

	localparam tw_tab_t COS_TAB = build_tab(1'b0);
	localparam tw_tab_t SIN_TAB = build_tab(1'b1);

	pout_t work_mem [NBANDS];

	logic run_q, pend_q, iss_q;
	logic [BAND_W-1:0] b_q, m_q;
	logic [2*BAND_W-1:0] bm;
	logic v_s1, first_s1, last_s1;
	logic [BAND_W-1:0] r_s1;
	pout_t work_rd_s1;
	logic signed [LO_W:0] lo;
	logic signed [HI_W-1:0] hi;
	logic signed [TW_W-1:0] tc, ts;
	logic v_s2, first_s2, last_s2;
	logic signed [LP_W-1:0] pcl_s2, psl_s2;
	logic signed [HP_W-1:0] pch_s2, psh_s2;
	logic signed [LACC_W-1:0] rl_q, il_q, rl_sum, il_sum;
	logic signed [HACC_W-1:0] rh_q, ih_q, rh_sum, ih_sum;
	logic fin_v_s3;
	logic signed [LACC_W-1:0] rl_s3, il_s3;
	logic signed [HACC_W-1:0] rh_s3, ih_s3;
	logic signed [TOT_W-1:0] re_tot, im_tot, re_sh, im_sh;
	logic res_v_q, res_last_q;
	logic [BAND_W-1:0] res_band_q;
	logic signed [31:0] res_re_q, res_im_q;

	// twiddle index (b*m) mod NBANDS
	assign bm = b_q * m_q;

	// scratch store with registered read
	always_ff @(posedge clk) begin
		if (pout_wr.valid) begin
			work_mem[pout_wr.m] <= pout_wr.data;
		end
		work_rd_s1 <= work_mem[m_q];
	end

	// split each sum so every product stays within 51 bits
	assign lo = signed'({1'b0, work_rd_s1[LO_W-1:0]});
	assign hi = work_rd_s1[POUT_W-1:LO_W];
	assign tc = COS_TAB[r_s1];
	assign ts = SIN_TAB[r_s1];

	assign rl_sum = (first_s2 ? '0 : rl_q) + LACC_W'(pcl_s2);
	assign il_sum = (first_s2 ? '0 : il_q) + LACC_W'(psl_s2);
	assign rh_sum = (first_s2 ? '0 : rh_q) + HACC_W'(pch_s2);
	assign ih_sum = (first_s2 ? '0 : ih_q) + HACC_W'(psh_s2);

	always_ff @(posedge clk) begin
		first_s1 <= (m_q == '0);
		last_s1 <= (m_q == BAND_W'(NBANDS - 1));
		r_s1 <= bm[BAND_W-1:0];
		pcl_s2 <= lo * tc;
		psl_s2 <= lo * ts;
		pch_s2 <= hi * tc;
		psh_s2 <= hi * ts;
		first_s2 <= first_s1;
		last_s2 <= last_s1;
		if (v_s2) begin
			rl_q <= rl_sum;
			il_q <= il_sum;
			rh_q <= rh_sum;
			ih_q <= ih_sum;
		end
		if (v_s2 && last_s2) begin
			rl_s3 <= rl_sum;
			il_s3 <= il_sum;
			rh_s3 <= rh_sum;
			ih_s3 <= ih_sum;
		end
	end

	// rejoin halves, round to q15; the range never reaches 32 bits so no clamp
	assign re_tot = (TOT_W'(rh_s3) <<< LO_W) + TOT_W'(rl_s3) + (TOT_W'(1) <<< (RSHIFT - 1));
	assign im_tot = (TOT_W'(ih_s3) <<< LO_W) + TOT_W'(il_s3) + (TOT_W'(1) <<< (RSHIFT - 1));
	assign re_sh = re_tot >>> RSHIFT;
	assign im_sh = im_tot >>> RSHIFT;

	// band sequencing and output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			pend_q <= 1'b0;
			iss_q <= 1'b0;
			b_q <= '0;
			m_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			fin_v_s3 <= 1'b0;
			res_v_q <= 1'b0;
			res_last_q <= 1'b0;
			res_band_q <= '0;
			res_re_q <= '0;
			res_im_q <= '0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
				pend_q <= 1'b1;
				b_q <= '0;
			end
			if (pend_q && !res_v_q) begin
				pend_q <= 1'b0;
				iss_q <= 1'b1;
				m_q <= '0;
			end
			if (iss_q) begin
				m_q <= m_q + BAND_W'(1);
				if (m_q == BAND_W'(NBANDS - 1)) begin
					iss_q <= 1'b0;
				end
			end
			v_s1 <= iss_q;
			v_s2 <= v_s1;
			fin_v_s3 <= v_s2 & last_s2;
			if (fin_v_s3) begin
				res_v_q <= 1'b1;
				res_band_q <= b_q;
				res_last_q <= (b_q == BAND_W'(NBANDS - 1));
				res_re_q <= re_sh[31:0];
				res_im_q <= im_sh[31:0];
				if (b_q == BAND_W'(NBANDS - 1)) begin
					run_q <= 1'b0;
				end else begin
					b_q <= b_q + BAND_W'(1);
					pend_q <= 1'b1;
				end
			end else if (res_take) begin
				res_v_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_v_q;
	assign res_band = res_band_q;
	assign res_re = res_re_q;
	assign res_im = res_im_q;
	assign res_last = res_last_q;
	assign busy = run_q;
endmodule

// ===== rtl/core/polyphase_dft_channelizer.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Analysis channelizer: real Q1.15 samples in, NBANDS complex subband words out.
// Input channel item_valid/item_stall carries either a sample (op sample) or a
// prototype coefficient write (op coef); coefficients must be loaded first.
// Output channel result_valid/result_stall carries band, re_part, im_part and
// last_band, one word per band, bands 0 to NBANDS-1 in order.
// decim_we/decim_data write the frame spacing shift decim; write only while idle.
// A coefficient word, or a sample that does not close a frame, leaves item_stall low.
// A sample that closes a frame (every NBANDS >> decim samples) holds the input
// off while the polyphase MACs run through the history and coefficient
// memories and their pipeline, and then while the 32 bands are formed one
// after another, as the one read port of the scratch memory is walked once
// per band.
// After reset all 256 history entries are cleared, one entry a cycle;
// item_stall is high meanwhile, decim_data may still be written.
// The last band word sits in the output register; the next input word is
// taken while it waits. A stalled result holds; the next band waits for it.
module polyphase_dft_channelizer import pdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic decim_we,
	input logic [DECIM_W-1:0] decim_data,
	input logic item_valid,
	output logic item_stall,
	input logic op,
	input logic signed [SAMPLE_W-1:0] sample,
	input logic [ADDR_W-1:0] coef_index,
	input logic signed [COEF_W-1:0] coef_value,
	output logic result_valid,
	input logic result_stall,
	output logic [BAND_W-1:0] band,
	output logic signed [31:0] re_part,
	output logic signed [31:0] im_part,
	output logic last_band
);
	logic [DECIM_W-1:0] decim_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W:0] d_raw, d_eff;
	logic frame_hit;
	logic acc, smp_acc, coef_acc;
	pout_wr_t pout_wr;
	pp_status_t pp_st;
	logic dft_busy;

	assign acc = item_valid & ~item_stall;
	assign smp_acc = acc && (op == OP_SAMPLE);
	assign coef_acc = acc && (op == OP_COEF);
	assign item_stall = pp_st.clearing | pp_st.busy | dft_busy;

	// frame spacing, at least one sample
	assign d_raw = (PHASE_W + 1)'(NBANDS >> decim_q);
	assign d_eff = (d_raw == '0) ? (PHASE_W + 1)'(1) : d_raw;
	assign frame_hit = ({1'b0, phase_q} + (PHASE_W + 1)'(1)) >= d_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decim_q <= DECIM_W'(1);
			phase_q <= '0;
		end else begin
			if (decim_we) begin
				decim_q <= decim_data;
			end
			if (smp_acc) begin
				phase_q <= frame_hit ? '0 : phase_q + PHASE_W'(1);
			end
		end
	end

	pdc_polyphase u_poly (
		.clk(clk),
		.arst_n(arst_n),
		.smp_we(smp_acc),
		.smp_data(sample),
		.frame_start(smp_acc & frame_hit),
		.coef_we(coef_acc),
		.coef_addr(coef_index),
		.coef_data(coef_value),
		.pout_wr(pout_wr),
		.status(pp_st)
	);

	pdc_dft u_dft (
		.clk(clk),
		.arst_n(arst_n),
		.pout_wr(pout_wr),
		.start(pp_st.done),
		.res_take(result_valid & ~result_stall),
		.res_valid(result_valid),
		.res_band(band),
		.res_re(re_part),
		.res_im(im_part),
		.res_last(last_band),
		.busy(dft_busy)
	);

	`ASSERT_IMPL(a_done_dft_idle, clk, arst_n, pp_st.done, !dft_busy, "frame done while busy")
	`ASSERT_NEXT(a_frame_starts, clk, arst_n, smp_acc && frame_hit, pp_st.busy, "no frame")
	`ASSERT_IMPL(a_last_band, clk, arst_n, result_valid && last_band, &band, "last word on wrong band")
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import pdc_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int LONG_HOLD = 3000;
	localparam int SETTLE = 60;
	localparam int Q29_ONE = 1 << 29;
	localparam longint unsigned PI_HALF = 64'd843314857;

	typedef struct {
		logic [BAND_W-1:0] band;
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic last;
	} band_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic decim_we = 1'b0;
	logic [DECIM_W-1:0] decim_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic op = OP_SAMPLE;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic [ADDR_W-1:0] coef_index = '0;
	logic signed [COEF_W-1:0] coef_value = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [BAND_W-1:0] band;
	logic signed [31:0] re_part;
	logic signed [31:0] im_part;
	logic last_band;

	// predictor state
	longint hist_mem [HLEN];
	longint coef_mem [HLEN];
	int hist_ptr;
	int phase_cnt;
	logic [DECIM_W-1:0] decim_cur;
	longint tw_c [NBANDS];
	longint tw_s [NBANDS];

	band_word_t band_q [$];
	int errors = 0;
	int frames_seen = 0;
	int words_sent = 0;
	longint cycles = 0;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;

	polyphase_dft_channelizer DUT (
		.clk(clk), .arst_n(arst_n),
		.decim_we(decim_we), .decim_data(decim_data),
		.item_valid(item_valid), .item_stall(item_stall),
		.op(op), .sample(sample), .coef_index(coef_index), .coef_value(coef_value),
		.result_valid(result_valid), .result_stall(result_stall),
		.band(band), .re_part(re_part), .im_part(im_part), .last_band(last_band)
	);

	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// taylor series of sin or cos in q29
	function automatic longint taylor_q29(longint unsigned a, bit is_sin);
		longint unsigned t;
		longint acc;
		longint unsigned j;
		t = is_sin ? a : Q29_ONE;
		acc = longint'(t);
		j = is_sin ? 2 : 1;
		for (int i = 1; i < 8; i++) begin
			t = (((t * a) >> 29) * a) >> 29;
			t = t / (j * (j + 1));
			j += 2;
			if (i & 1) acc -= longint'(t);
			else acc += longint'(t);
		end
		if (acc < 0) acc = 0;
		if (acc > Q29_ONE) acc = Q29_ONE;
		return acc;
	endfunction

	function automatic void build_twiddle_table();
		int q, rm;
		longint unsigned a;
		longint c, s;
		for (int r = 0; r < NBANDS; r++) begin
			q = (4 * r) / NBANDS;
			rm = 4 * r - q * NBANDS;
			a = (PI_HALF * rm + NBANDS / 2) / NBANDS;
			c = taylor_q29(a, 1'b0);
			s = taylor_q29(a, 1'b1);
			case (q & 3)
				0: begin tw_c[r] = c; tw_s[r] = s; end
				1: begin tw_c[r] = -s; tw_s[r] = c; end
				2: begin tw_c[r] = -c; tw_s[r] = -s; end
				default: begin tw_c[r] = s; tw_s[r] = -c; end
			endcase
		end
	endfunction

	// rounding to q15 and saturation
	function automatic logic signed [31:0] round_sat(longint hs, longint ls);
		longint low, v;
		low = (ls + (longint'(1) <<< 45)) >>> 27;
		v = (hs + low) >>> 19;
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	// work out the band words that one accepted input word causes
	function automatic void predict_bands(logic w_op, logic signed [SAMPLE_W-1:0] w_s,
			logic [ADDR_W-1:0] w_idx, logic signed [COEF_W-1:0] w_c);
		int dlen;
		longint acc, hr, lr, hm, lm;
		longint hi [NBANDS];
		longint lo [NBANDS];
		band_word_t bw;
		if (w_op == OP_COEF) begin
			coef_mem[w_idx] = longint'(w_c);
			return;
		end
		hist_mem[hist_ptr] = longint'(w_s);
		hist_ptr = (hist_ptr + 1) % HLEN;
		dlen = NBANDS >> decim_cur;
		if (dlen == 0) dlen = 1;
		if (phase_cnt + 1 < dlen) begin
			phase_cnt++;
			return;
		end
		phase_cnt = 0;
		for (int m = 0; m < NBANDS; m++) begin
			acc = 0;
			for (int k = 0; k < NTAPS; k++)
				acc += coef_mem[m + k * NBANDS] *
					hist_mem[(hist_ptr + HLEN - 1 - m - k * NBANDS) % HLEN];
			hi[m] = acc >>> 27;
			lo[m] = acc - (hi[m] <<< 27);
		end
		for (int b = 0; b < NBANDS; b++) begin
			hr = 0; lr = 0; hm = 0; lm = 0;
			for (int m = 0; m < NBANDS; m++) begin
				hr += hi[m] * tw_c[(b * m) % NBANDS];
				lr += lo[m] * tw_c[(b * m) % NBANDS];
				hm += hi[m] * tw_s[(b * m) % NBANDS];
				lm += lo[m] * tw_s[(b * m) % NBANDS];
			end
			bw.band = b[BAND_W-1:0];
			bw.re = round_sat(hr, lr);
			bw.im = round_sat(hm, lm);
			bw.last = (b == NBANDS - 1);
			band_q.push_back(bw);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		band_word_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (band_q.size() == 0) begin
				$display("%0t: unexpected band word band=%0d re=%0d im=%0d", $time,
					band, re_part, im_part);
				errors++;
			end else begin
				e = band_q.pop_front();
				if (band !== e.band) begin
					$display("%0t: band exp %0d got %0d", $time, e.band, band);
					errors++;
				end
				if (re_part !== e.re) begin
					$display("%0t: re_part band %0d exp %0d got %0d", $time, e.band, e.re,
						re_part);
					errors++;
				end
				if (im_part !== e.im) begin
					$display("%0t: im_part band %0d exp %0d got %0d", $time, e.band, e.im,
						im_part);
					errors++;
				end
				if (last_band !== e.last) begin
					$display("%0t: last_band band %0d exp %0d got %0d", $time, e.band,
						e.last, last_band);
					errors++;
				end
				if (e.last) frames_seen++;
			end
		end
	end

	// receiver stall, random bursts and one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				result_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// offer one word and wait until it is taken
	task automatic send_word(logic w_op, logic signed [SAMPLE_W-1:0] w_s,
			logic [ADDR_W-1:0] w_idx, logic signed [COEF_W-1:0] w_c);
		item_valid <= 1'b1;
		op <= w_op;
		sample <= w_s;
		coef_index <= w_idx;
		coef_value <= w_c;
		do @(posedge clk); while (item_stall);
		predict_bands(w_op, w_s, w_idx, w_c);
		words_sent++;
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
		send_word(OP_SAMPLE, s, ADDR_W'($urandom), COEF_W'($urandom));
	endtask

	task automatic send_coef(logic [ADDR_W-1:0] idx, logic signed [COEF_W-1:0] c);
		send_word(OP_COEF, SAMPLE_W'($urandom), idx, c);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 15))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// pause the sender until every band word is in, then let the block settle
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (band_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_decim(logic [DECIM_W-1:0] v);
		drain();
		decim_we <= 1'b1;
		decim_data <= v;
		@(posedge clk);
		decim_we <= 1'b0;
		decim_cur = v;
	endtask

	task automatic test_coef_load();
		send_coef(ADDR_W'(0), 18'sh20000);
		send_coef(ADDR_W'(1), 18'sh1ffff);
		for (int i = 2; i < HLEN; i++)
			send_coef(i[ADDR_W-1:0], COEF_W'($urandom));
	endtask

	task automatic test_directed();
		// extremes at the reset decimation
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(16'shffff);
		for (int i = 0; i < 12; i++) send_sample(i[0] ? 16'sh7fff : 16'sh8000);
		// shift too large: a frame on every sample
		write_decim(3'd7);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		// shift 0, a frame every NBANDS samples, then change mid-frame
		write_decim(3'd0);
		for (int i = 0; i < 5; i++) send_sample(rand_sample());
		write_decim(3'd2);
		for (int i = 0; i < 3; i++) send_sample(rand_sample());
	endtask

	task automatic test_random(logic [DECIM_W-1:0] d, int n);
		write_decim(d);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) send_coef(ADDR_W'($urandom), COEF_W'($urandom));
			else send_sample(rand_sample());
		end
	endtask

	task automatic test_backpressure();
		write_decim(3'd5);
		hold_req = 1'b1;
		for (int i = 0; i < 6; i++) send_sample(rand_sample());
	endtask

	initial begin
		for (int i = 0; i < HLEN; i++) begin
			hist_mem[i] = 0;
			coef_mem[i] = 0;
		end
		hist_ptr = 0;
		phase_cnt = 0;
		decim_cur = 3'd1;
		build_twiddle_table();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_coef_load();
		test_directed();
		test_random(3'd1, 14);
		test_random(3'd0, 6);
		test_random(3'd3, 6);
		test_random(3'd6, 4);
		test_backpressure();
		test_random(3'd4, 4);
		no_idle = 1'b1;
		test_random(3'd5, 4);
		test_random(3'd1, 8);
		drain();
		$display("covered %0d input words and %0d frames over decimation 0 to 7,", words_sent,
			frames_seen);
		$display("with coefficient rewrites, random stalls and a long output hold-off");
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pdc_pkg.sv
rtl/core/pdc_polyphase.sv
rtl/core/pdc_dft.sv
rtl/core/polyphase_dft_channelizer.sv
dv/tb_top.sv
